/* design/kwl_pkg.sv */
// kwl_pkg: types, codes and character constants shared by the keyword token lexer
// no dependencies; imported by the lexer core, the result buffer and the top
`default_nettype none

package kwl_pkg;

    // lexer mode register
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_DATA    = 2'd2,
        MODE_WORD    = 2'd3
    } t_mode;

    // token kinds
    localparam logic [3:0] KIND_WORD    = 4'd0;
    localparam logic [3:0] KIND_TRIGGER = 4'd1;
    localparam logic [3:0] KIND_DATA    = 4'd2;
    localparam logic [3:0] KIND_COLON   = 4'd3;
    localparam logic [3:0] KIND_LESS    = 4'd4;
    localparam logic [3:0] KIND_EQUALS  = 4'd5;
    localparam logic [3:0] KIND_LBRACE  = 4'd6;
    localparam logic [3:0] KIND_RBRACE  = 4'd7;
    localparam logic [3:0] KIND_LPAREN  = 4'd8;
    localparam logic [3:0] KIND_RPAREN  = 4'd9;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_UNDEF    = 2'd1;
    localparam logic [1:0] STAT_UNTERM   = 2'd2;
    localparam logic [1:0] STAT_END      = 2'd3;

    // character codes
    localparam logic [7:0] CH_END     = 8'h00;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    // keyword length
    localparam logic [2:0] KW_LEN = 3'd7;

    // one result beat
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] text_byte;
        logic       has_byte;
        logic       token_done;
        logic [1:0] status;
        logic       result_last;
    } t_result;

    // everything the core hands to the result buffer for one input byte
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step_out;

    // keyword "trigger", one character per position
    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h74; // t
            3'd1:    ch = 8'h72; // r
            3'd2:    ch = 8'h69; // i
            3'd3:    ch = 8'h67; // g
            3'd4:    ch = 8'h67; // g
            3'd5:    ch = 8'h65; // e
            3'd6:    ch = 8'h72; // r
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

/* design/kwl_if.sv */
// kwl_if: valid/ready channel interfaces for source bytes and token results
// no dependencies
`default_nettype none

interface kwl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface kwl_token_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] text_byte;
    logic       has_byte;
    logic       token_done;
    logic [1:0] status;
    logic       result_last;

    modport source (output valid, output kind, output text_byte, output has_byte,
                    output token_done, output status, output result_last, input ready);
    modport sink   (input valid, input kind, input text_byte, input has_byte,
                    input token_done, input status, input result_last, output ready);
endinterface

`default_nettype wire

/* design/kwl_lexer_core.sv */
// kwl_lexer_core: lexer mode and keyword matcher registers plus the per-byte step logic
// depends on kwl_pkg
`default_nettype none

module kwl_lexer_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [7:0]         i_char_code,
    output kwl_pkg::t_step_out      o_step
);
    import kwl_pkg::*;

    typedef struct packed {
        t_mode      mode;
        logic [2:0] cnt;
        logic       mism;
    } t_lex_state;

    typedef struct packed {
        t_lex_state st;
        logic       emit;
        t_result    res;
    } t_idle_out;

    localparam t_lex_state ST_CLEAR = '{mode: MODE_IDLE, cnt: 3'd0, mism: 1'b0};

    t_lex_state r_st;
    t_lex_state n_st;

    function automatic t_result mk_res(input logic [3:0] kind, input logic [7:0] b,
                                       input logic hb, input logic done,
                                       input logic [1:0] stat);
        t_result r;
        r.kind        = kind;
        r.text_byte   = b;
        r.has_byte    = hb;
        r.token_done  = done;
        r.status      = stat;
        r.result_last = 1'b0;
        return r;
    endfunction

    // keyword matcher advance
    function automatic t_lex_state match_byte(input t_lex_state s, input logic [7:0] c);
        t_lex_state o;
        o = s;
        if (!s.mism && (s.cnt < KW_LEN) && (c == kw_char(s.cnt))) begin
            o.cnt = s.cnt + 3'd1;
        end else begin
            o.mism = 1'b1;
        end
        return o;
    endfunction

    // operator kind; valid flag in bit 4
    function automatic logic [4:0] op_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            CH_COLON:  k = {1'b1, KIND_COLON};
            CH_LESS:   k = {1'b1, KIND_LESS};
            CH_EQUALS: k = {1'b1, KIND_EQUALS};
            CH_LBRACE: k = {1'b1, KIND_LBRACE};
            CH_RBRACE: k = {1'b1, KIND_RBRACE};
            CH_LPAREN: k = {1'b1, KIND_LPAREN};
            CH_RPAREN: k = {1'b1, KIND_RPAREN};
            default:   k = 5'd0;
        endcase
        return k;
    endfunction

    // handling of one byte starting from idle
    function automatic t_idle_out idle_step(input t_lex_state s, input logic [7:0] c);
        t_idle_out o;
        logic [4:0] op;
        op     = op_kind(c);
        o.st   = s;
        o.emit = 1'b0;
        o.res  = mk_res(KIND_WORD, 8'd0, 1'b0, 1'b0, STAT_OK);
        if (c == CH_END) begin
            o.st   = ST_CLEAR;
            o.emit = 1'b1;
            o.res  = mk_res(KIND_WORD, 8'd0, 1'b0, 1'b0, STAT_END);
        end else if (c == CH_HASH) begin
            o.st.mode = MODE_COMMENT;
        end else if (c == CH_QUOTE) begin
            o.st.mode = MODE_DATA;
        end else if (is_letter(c) || (c == CH_UNDER)) begin
            o.st   = match_byte('{mode: MODE_WORD, cnt: 3'd0, mism: 1'b0}, c);
            o.emit = 1'b1;
            o.res  = mk_res(KIND_WORD, c, 1'b1, 1'b0, STAT_OK);
        end else if (op[4]) begin
            o.emit = 1'b1;
            o.res  = mk_res(op[3:0], c, 1'b1, 1'b1, STAT_OK);
        end else if (is_space(c)) begin
            o.emit = 1'b0;
        end else begin
            o.st   = ST_CLEAR;
            o.emit = 1'b1;
            o.res  = mk_res(KIND_WORD, 8'd0, 1'b0, 1'b0, STAT_UNDEF);
        end
        return o;
    endfunction

    // step logic for the current mode
    always_comb begin
        t_idle_out io;
        logic [3:0] wkind;
        io    = idle_step(ST_CLEAR, i_char_code);
        wkind = KIND_WORD;
        n_st  = r_st;
        o_step.count = 2'd0;
        o_step.res0  = mk_res(KIND_WORD, 8'd0, 1'b0, 1'b0, STAT_OK);
        o_step.res1  = mk_res(KIND_WORD, 8'd0, 1'b0, 1'b0, STAT_OK);
        unique case (r_st.mode)
            MODE_COMMENT: begin
                if (i_char_code == CH_NEWLINE) begin
                    n_st.mode = MODE_IDLE;
                end else if (i_char_code == CH_END) begin
                    n_st         = ST_CLEAR;
                    o_step.count = 2'd1;
                    o_step.res0  = mk_res(KIND_WORD, 8'd0, 1'b0, 1'b0, STAT_END);
                end
            end
            MODE_DATA: begin
                o_step.count = 2'd1;
                if (i_char_code == CH_END) begin
                    n_st        = ST_CLEAR;
                    o_step.res0 = mk_res(KIND_WORD, 8'd0, 1'b0, 1'b0, STAT_UNTERM);
                end else if (i_char_code == CH_QUOTE) begin
                    n_st.mode   = MODE_IDLE;
                    o_step.res0 = mk_res(KIND_DATA, 8'd0, 1'b0, 1'b1, STAT_OK);
                end else begin
                    o_step.res0 = mk_res(KIND_DATA, i_char_code, 1'b1, 1'b0, STAT_OK);
                end
            end
            MODE_WORD: begin
                if (is_letter(i_char_code) || is_digit(i_char_code) ||
                    (i_char_code == CH_UNDER)) begin
                    n_st         = match_byte(r_st, i_char_code);
                    o_step.count = 2'd1;
                    o_step.res0  = mk_res(KIND_WORD, i_char_code, 1'b1, 1'b0, STAT_OK);
                end else begin
                    // close the word, then treat the byte from idle
                    if (!r_st.mism && (r_st.cnt == KW_LEN)) begin
                        wkind = KIND_TRIGGER;
                    end
                    o_step.res0  = mk_res(wkind, 8'd0, 1'b0, 1'b1, STAT_OK);
                    n_st         = io.st;
                    o_step.res1  = io.res;
                    o_step.count = io.emit ? 2'd2 : 2'd1;
                end
            end
            MODE_IDLE: begin
                io           = idle_step(r_st, i_char_code);
                n_st         = io.st;
                o_step.res0  = io.res;
                o_step.count = io.emit ? 2'd1 : 2'd0;
            end
            default: begin
                n_st = ST_CLEAR;
            end
        endcase
        // mark the last result of this byte
        if (o_step.count == 2'd1) begin
            o_step.res0.result_last = 1'b1;
        end
        if (o_step.count == 2'd2) begin
            o_step.res1.result_last = 1'b1;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR;
        end else if (i_accept) begin
            r_st <= n_st;
        end
    end

endmodule

`default_nettype wire

/* design/kwl_result_buf.sv */
// kwl_result_buf: two-slot result register that holds the beats of one source byte
// depends on kwl_pkg
`default_nettype none

module kwl_result_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire kwl_pkg::t_step_out i_step,
    input  wire logic               i_pop_ready,
    output logic                    o_can_load,
    output logic                    o_valid,
    output kwl_pkg::t_result        o_res
);
    import kwl_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_result    r_slot0;
    t_result    r_slot1;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_slot0;
    assign pop     = o_valid && i_pop_ready;

    // a new byte may load once the buffer drains in this cycle
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_pop_ready);

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_step.count;
        end else if (pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // result slots
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot0 <= i_step.res0;
            r_slot1 <= i_step.res1;
        end else if (pop) begin
            r_slot0 <= r_slot1;
        end
    end

endmodule

`default_nettype wire

/* design/keyword_token_lexer.sv */
// keyword_token_lexer: one source byte per beat in, token result beats out
// output: an accepted byte's first result beat is registered and offered the cycle after
// throughput: one byte per cycle while results are taken; a byte with two results stalls input
// reset: synchronous active-low; lexer returns to idle with the keyword matcher cleared
// depends on kwl_pkg, kwl_if, kwl_lexer_core, kwl_result_buf
`default_nettype none

module keyword_token_lexer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    kwl_char_if.sink        i_char,
    kwl_token_if.source     o_tok
);
    import kwl_pkg::*;

    logic      can_load;
    logic      accept;
    t_step_out step;
    t_result   res;

    assign i_char.ready = can_load;
    assign accept       = i_char.valid && can_load;

    // mode and keyword matcher
    kwl_lexer_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_code (i_char.char_code),
        .o_step      (step)
    );

    // result register
    kwl_result_buf u_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_step      (step),
        .i_pop_ready (o_tok.ready),
        .o_can_load  (can_load),
        .o_valid     (o_tok.valid),
        .o_res       (res)
    );

    assign o_tok.kind        = res.kind;
    assign o_tok.text_byte   = res.text_byte;
    assign o_tok.has_byte    = res.has_byte;
    assign o_tok.token_done  = res.token_done;
    assign o_tok.status      = res.status;
    assign o_tok.result_last = res.result_last;

endmodule

`default_nettype wire

/* tb/sv/kwl_token_checker_pkg.sv */
`timescale 1ns / 1ps
// kwl_token_checker_pkg: expected token beats for the keyword token lexer test and their check
// depends on kwl_pkg for the result beat type, token kinds, status codes and character codes
package kwl_token_checker_pkg;
    import kwl_pkg::*;

    localparam logic [55:0] KEYWORD_TEXT = "trigger";

    class token_checker;
        t_mode      mode;
        logic [2:0] kw_count;
        logic       kw_miss;
        t_result    pending_tokens[$];
        int         mismatches;
        int         accepted_bytes;
        int         beats_seen;

        function new();
            clear_lexer();
            mismatches     = 0;
            accepted_bytes = 0;
            beats_seen     = 0;
        endfunction

        function void clear_lexer();
            mode     = MODE_IDLE;
            kw_count = 3'd0;
            kw_miss  = 1'b0;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function int pending();
            return pending_tokens.size();
        endfunction

        // follow the word against "trigger"; any step off the path sticks
        function void track_keyword(logic [7:0] c);
            int idx;
            idx = 6 - int'(kw_count);
            if (!kw_miss && kw_count < KW_LEN) begin
                if (c == KEYWORD_TEXT[8*idx +: 8])
                    kw_count = kw_count + 3'd1;
                else
                    kw_miss = 1'b1;
            end else begin
                kw_miss = 1'b1;
            end
        endfunction

        function void push_token(logic [3:0] kind, logic [7:0] b, logic hb, logic done,
                                 logic [1:0] st);
            t_result r;
            r.kind        = kind;
            r.text_byte   = b;
            r.has_byte    = hb;
            r.token_done  = done;
            r.status      = st;
            r.result_last = 1'b0;
            pending_tokens.insert(pending_tokens.size(), r);
        endfunction

        function bit op_lookup(logic [7:0] c, output logic [3:0] kind);
            bit hit;
            hit = 1'b1;
            case (c)
                CH_COLON:  kind = KIND_COLON;
                CH_LESS:   kind = KIND_LESS;
                CH_EQUALS: kind = KIND_EQUALS;
                CH_LBRACE: kind = KIND_LBRACE;
                CH_RBRACE: kind = KIND_RBRACE;
                CH_LPAREN: kind = KIND_LPAREN;
                CH_RPAREN: kind = KIND_RPAREN;
                default: begin
                    kind = KIND_WORD;
                    hit  = 1'b0;
                end
            endcase
            return hit;
        endfunction

        // a byte seen with the lexer idle
        function void take_from_idle(logic [7:0] c);
            logic [3:0] kind;
            if (c == CH_END) begin
                clear_lexer();
                push_token(KIND_WORD, 8'h00, 1'b0, 1'b0, STAT_END);
            end else if (c == CH_HASH) begin
                mode = MODE_COMMENT;
            end else if (c == CH_QUOTE) begin
                mode = MODE_DATA;
            end else if (is_alpha(c) || c == CH_UNDER) begin
                mode     = MODE_WORD;
                kw_count = 3'd0;
                kw_miss  = 1'b0;
                track_keyword(c);
                push_token(KIND_WORD, c, 1'b1, 1'b0, STAT_OK);
            end else if (op_lookup(c, kind)) begin
                push_token(kind, c, 1'b1, 1'b1, STAT_OK);
            end else if (!is_blank(c)) begin
                clear_lexer();
                push_token(KIND_WORD, 8'h00, 1'b0, 1'b0, STAT_UNDEF);
            end
        endfunction

        // accepted source byte: advance the lexer and queue the beats it causes
        function void note_byte(logic [7:0] c);
            int         queued;
            logic [3:0] kind;
            queued = pending_tokens.size();
            case (mode)
                MODE_COMMENT: begin
                    if (c == CH_NEWLINE)
                        mode = MODE_IDLE;
                    else if (c == CH_END)
                        take_from_idle(c);
                end
                MODE_DATA: begin
                    if (c == CH_END) begin
                        clear_lexer();
                        push_token(KIND_WORD, 8'h00, 1'b0, 1'b0, STAT_UNTERM);
                    end else if (c == CH_QUOTE) begin
                        mode = MODE_IDLE;
                        push_token(KIND_DATA, 8'h00, 1'b0, 1'b1, STAT_OK);
                    end else begin
                        push_token(KIND_DATA, c, 1'b1, 1'b0, STAT_OK);
                    end
                end
                MODE_WORD: begin
                    if (is_alpha(c) || is_num(c) || c == CH_UNDER) begin
                        track_keyword(c);
                        push_token(KIND_WORD, c, 1'b1, 1'b0, STAT_OK);
                    end else begin
                        // word ends here, the closing byte is lexed again from idle
                        kind = (!kw_miss && kw_count == KW_LEN) ? KIND_TRIGGER : KIND_WORD;
                        push_token(kind, 8'h00, 1'b0, 1'b1, STAT_OK);
                        clear_lexer();
                        take_from_idle(c);
                    end
                end
                default: take_from_idle(c);
            endcase
            // mark the final beat of this byte
            if (pending_tokens.size() > queued)
                pending_tokens[pending_tokens.size() - 1].result_last = 1'b1;
            accepted_bytes++;
        endfunction

        task report(string what);
            mismatches++;
            $display("mismatch at beat %0d: %s", beats_seen, what);
        endtask

        task compare_field(string name, logic [7:0] got_v, logic [7:0] want_v);
            if (got_v !== want_v)
                report($sformatf("%s is %0h, expected %0h", name, got_v, want_v));
        endtask

        // accepted result beat against the oldest expected one
        task check_token(t_result got);
            t_result want;
            beats_seen++;
            if (pending_tokens.size() == 0) begin
                report($sformatf("beat with nothing expected, kind %0h byte %0h status %0h",
                                 got.kind, got.text_byte, got.status));
            end else begin
                want = pending_tokens.pop_front();
                compare_field("kind", 8'(got.kind), 8'(want.kind));
                compare_field("text_byte", got.text_byte, want.text_byte);
                compare_field("has_byte", 8'(got.has_byte), 8'(want.has_byte));
                compare_field("token_done", 8'(got.token_done), 8'(want.token_done));
                compare_field("status", 8'(got.status), 8'(want.status));
                compare_field("result_last", 8'(got.result_last), 8'(want.result_last));
            end
        endtask
    endclass

endpackage

/* tb/sv/keyword_token_lexer_test.sv */
`timescale 1ns / 1ps
// keyword_token_lexer_test: feeds source text into the lexer and checks every token beat
// depends on kwl_pkg, kwl_if, keyword_token_lexer and kwl_token_checker_pkg
module keyword_token_lexer_test;
    import kwl_pkg::*;
    import kwl_token_checker_pkg::*;

    localparam int TARGET_BYTES = 1900;
    localparam int QUIET_BYTES  = 200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [7:0] CH_VTAB     = 8'h0B;
    localparam logic [7:0] CH_FORMFEED = 8'h0C;
    localparam logic [7:0] CH_PIPE     = 8'h7C;

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    int   stall_left;
    int   cycle_count;

    token_checker tok_check;
    t_result      seen;

    logic [7:0] op_chars[7] = '{CH_COLON, CH_LESS, CH_EQUALS, CH_LBRACE, CH_RBRACE,
                                CH_LPAREN, CH_RPAREN};
    logic [7:0] blank_chars[6] = '{CH_SPACE, CH_TAB, CH_NEWLINE, CH_VTAB, CH_FORMFEED, CH_CR};
    string keyword_forms[13] = '{"trigger", "trigge", "triggers", "trigger_", "Trigger",
                                 "triggeR", "t", "tr", "trigger9", "xtrigger", "ttrigger",
                                 "triggerr", "trig"};

    kwl_char_if  char_bus();
    kwl_token_if tok_bus();

    keyword_token_lexer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_tok   (tok_bus)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result side: stall in short random bursts while idling is on
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            tok_bus.ready <= 1'b0;
        end else if (idle_on && i_rst_n && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 3);
            tok_bus.ready <= 1'b0;
        end else begin
            tok_bus.ready <= 1'b1;
        end
    end

    // watch both channels, values as they stood at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (char_bus.valid && char_bus.ready)
                tok_check.note_byte(char_bus.char_code);
            if (tok_bus.valid && tok_bus.ready) begin
                seen.kind        = tok_bus.kind;
                seen.text_byte   = tok_bus.text_byte;
                seen.has_byte    = tok_bus.has_byte;
                seen.token_done  = tok_bus.token_done;
                seen.status      = tok_bus.status;
                seen.result_last = tok_bus.result_last;
                tok_check.check_token(seen);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one source beat, with an optional gap ahead of it
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 6) == 0) begin
            char_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= b;
        do @(posedge i_clk); while (!char_bus.ready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] word_char(input bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26)
            return 8'h41 + 8'(r);
        else if (r < 52)
            return 8'h61 + 8'(r - 26);
        else if (r == 52)
            return CH_UNDER;
        else
            return 8'h30 + 8'(r - 53);
    endfunction

    // identifier, often close to the keyword
    task automatic send_word();
        int len;
        if ($urandom_range(0, 2) == 0) begin
            send_text(keyword_forms[$urandom_range(0, 12)]);
        end else begin
            len = $urandom_range(1, 10);
            send_byte(word_char(1'b1));
            for (int i = 1; i < len; i++)
                send_byte(word_char(1'b0));
        end
    endtask

    // quoted data, now and then left open at end of text
    task automatic send_data();
        int         len;
        logic [7:0] b;
        send_byte(CH_QUOTE);
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(1, 255));
            if (b == CH_QUOTE)
                b = b + 8'd1;
            send_byte(b);
        end
        if ($urandom_range(0, 9) == 0)
            send_byte(CH_END);
        else
            send_byte(CH_QUOTE);
    endtask

    // comment closed by newline or by end of text
    task automatic send_comment();
        int         len;
        logic [7:0] b;
        send_byte(CH_HASH);
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(1, 255));
            if (b == CH_NEWLINE)
                b = b + 8'd1;
            send_byte(b);
        end
        if ($urandom_range(0, 5) == 0)
            send_byte(CH_END);
        else
            send_byte(CH_NEWLINE);
    endtask

    // stray bytes: anything, digits, pipe, high bytes
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0:       send_byte(8'($urandom_range(0, 255)));
            1:       send_byte(8'h30 + 8'($urandom_range(0, 9)));
            2:       send_byte(CH_PIPE);
            default: send_byte(8'($urandom_range(128, 255)));
        endcase
    endtask

    initial begin
        int pick;
        tok_check          = new();
        i_rst_n            = 1'b0;
        idle_on            = 1'b1;
        stall_left         = 0;
        cycle_count        = 0;
        char_bus.valid     = 1'b0;
        char_bus.char_code = 8'h00;
        tok_bus.ready      = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // keyword closed by an operator, word closed by an undefined byte
        send_text("trigger:");
        send_text("_9");
        send_byte(CH_PIPE);
        // closed quote with a high byte, then a quote left open
        send_byte(CH_QUOTE);
        send_byte(8'hFF);
        send_byte(CH_QUOTE);
        send_byte(CH_QUOTE);
        send_byte(8'h80);
        send_byte(CH_END);
        // comment ended by newline, comment ended by end of text
        send_byte(CH_HASH);
        send_text("x");
        send_byte(CH_NEWLINE);
        send_byte(CH_HASH);
        send_byte(CH_END);
        // stray digit, operator, end of text from idle
        send_text("5{");
        send_byte(CH_END);

        // random token streams with some noise mixed in
        while (tok_check.accepted_bytes < TARGET_BYTES) begin
            if (tok_check.accepted_bytes >= TARGET_BYTES - QUIET_BYTES)
                idle_on = 1'b0;
            else if ($urandom_range(0, 15) == 0)
                idle_on = ~idle_on;
            if ($urandom_range(0, 2) == 0)
                send_byte(blank_chars[$urandom_range(0, 5)]);
            pick = $urandom_range(0, 99);
            if (pick < 32)
                send_word();
            else if (pick < 54)
                send_byte(op_chars[$urandom_range(0, 6)]);
            else if (pick < 66)
                send_data();
            else if (pick < 75)
                send_comment();
            else if (pick < 80)
                send_byte(CH_END);
            else
                send_noise();
        end
        char_bus.valid <= 1'b0;

        // drain
        @(posedge i_clk);
        while (tok_check.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tok_check.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
